### hdl/isr_pkg.sv
// Shared widths, constants and control types of the integer square root unit.
package isr_pkg;

    localparam int unsigned VALUE_W = 31;
    localparam int unsigned ROOT_W  = 16;
    localparam int unsigned WORK_W  = 32;

    localparam logic [WORK_W-1:0] BIT_INIT = 32'h4000_0000;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic last_step;
    } status_t;

endpackage

### hdl/isr_if.sv
// Request and response channel interfaces of the integer square root unit.
interface isr_req_if;
    logic                          valid;
    logic                          ready;
    logic [isr_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface isr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [isr_pkg::ROOT_W-1:0]    root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

### hdl/isr_dp.sv
// Datapath: digit-by-digit square root, one root bit per step, and the result register.
module isr_dp (
    input  logic                          clk,
    input  isr_pkg::cmd_t                 cmd,
    input  logic [isr_pkg::VALUE_W-1:0]   value,
    output isr_pkg::status_t              status,
    output logic [isr_pkg::ROOT_W-1:0]    root
);

    logic [isr_pkg::WORK_W-1:0] rem_reg;
    logic [isr_pkg::WORK_W-1:0] rem_next;
    logic [isr_pkg::WORK_W-1:0] acc_reg;
    logic [isr_pkg::WORK_W-1:0] acc_next;
    logic [isr_pkg::WORK_W-1:0] bit_reg;
    logic [isr_pkg::WORK_W-1:0] bit_next;
    logic [isr_pkg::ROOT_W-1:0] root_reg;
    logic [isr_pkg::ROOT_W-1:0] root_next;
    logic [isr_pkg::WORK_W-1:0] trial;
    logic                       fits;

    assign trial = acc_reg + bit_reg;
    assign fits  = (rem_reg >= trial);

    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        if (cmd.load)
        begin
            rem_next = {1'b0, value};
            acc_next = '0;
            bit_next = isr_pkg::BIT_INIT;
        end
        else if (cmd.step)
        begin
            if (fits)
            begin
                rem_next = rem_reg - trial;
                acc_next = (acc_reg >> 1) + bit_reg;
            end
            else
            begin
                acc_next = acc_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        if (cmd.capture)
        begin
            root_next = acc_reg[isr_pkg::ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign status.last_step = bit_reg[0];
    assign root             = root_reg;

endmodule

### hdl/isr_ctrl.sv
// Controller: sequences load, sixteen steps and result capture; owns the handshakes.
module isr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  isr_pkg::status_t   status,
    output isr_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        req_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.capture    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> rsp_valid_reg)
        else $error("response not raised after capture");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_RUN))
        else $error("accepted request did not start a run");

    a_no_capture_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && rsp_valid_reg) |-> rsp_ready)
        else $error("capture overwrote a pending response");

    a_busy_blocks_request: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req_ready)
        else $error("request accepted while busy");

endmodule

### hdl/integer_square_root_unit.sv
// Top level of the integer square root unit: controller and datapath.
//
//  channel    dir   payload            width
//  request    in    value (unsigned)   31
//  response   out   root  (unsigned)   16
//
// For one request, the accepting edge loads, sixteen restoring steps of the
// shared compare-subtract unit follow, then one capture; the response valid
// is registered from the capture.
// A new request is taken once the capture is done, even while the previous
// response still waits; a stalled response holds the run in its last state.
// Reset clears the controller and the response valid; no clearing pass.
module integer_square_root_unit (
    input  logic         clk,
    input  logic         rst_n,
    isr_req_if.sink      request,
    isr_rsp_if.source    response
);

    isr_pkg::cmd_t    cmd;
    isr_pkg::status_t status;

    isr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .status    (status),
        .cmd       (cmd)
    );

    isr_dp u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .value  (request.value),
        .status (status),
        .root   (response.root)
    );

endmodule

### tb/root_scoreboard_pkg.sv
// Scoreboard class that predicts and checks square root responses.
package root_scoreboard_pkg;

    class root_scoreboard;

        typedef struct {
            logic [isr_pkg::VALUE_W-1:0] value;
            logic [isr_pkg::ROOT_W-1:0]  root;
        } root_expect_t;

        root_expect_t pending_roots[$];
        int unsigned  failures;

        function new();
            failures = 0;
        endfunction

        function logic [isr_pkg::ROOT_W-1:0] floor_root(logic [isr_pkg::VALUE_W-1:0] value);
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] mid;
            logic [31:0] best;
            logic [63:0] square;
            if (value < 2)
            begin
                return value[isr_pkg::ROOT_W-1:0];
            end
            lo   = 32'd2;
            hi   = {1'b0, value} >> 1;
            best = 32'd1;
            while (lo <= hi)
            begin
                mid    = lo + (hi - lo) / 2;
                square = {32'd0, mid} * {32'd0, mid};
                if (square <= {33'd0, value})
                begin
                    best = mid;
                    lo   = mid + 1;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            return best[isr_pkg::ROOT_W-1:0];
        endfunction

        function void note_value(logic [isr_pkg::VALUE_W-1:0] value);
            root_expect_t entry;
            entry.value = value;
            entry.root  = floor_root(value);
            pending_roots.insert(pending_roots.size(), entry);
        endfunction

        function void check_root(logic [isr_pkg::ROOT_W-1:0] root);
            root_expect_t entry;
            if (pending_roots.size() == 0)
            begin
                $error("root: no request outstanding, actual %0d", root);
                failures++;
                return;
            end
            entry = pending_roots.pop_front();
            if (root !== entry.root)
            begin
                $error("root: expected %0d, actual %0d (value %0d)",
                       entry.root, root, entry.value);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_roots.size();
        endfunction

    endclass

endpackage

### tb/tb_integer_square_root_unit.sv
// Testbench top that drives and checks the integer square root unit.
module tb_integer_square_root_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned BURST_ITEMS     = 24;
    localparam int unsigned RANDOM_ITEMS    = 900;
    localparam int unsigned QUIET_ITEMS     = 150;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned DIRECTED_COUNT  = 25;

    logic clk;
    logic rst_n;

    isr_req_if request();
    isr_rsp_if response();

    root_scoreboard_pkg::root_scoreboard roots = new();

    bit req_gaps_on;
    bit rsp_stalls_on;
    bit hold_off_pending;

    logic [isr_pkg::VALUE_W-1:0] directed_values [DIRECTED_COUNT] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd8, 31'd9, 31'd10,
        31'd15, 31'd16, 31'd17, 31'd24, 31'd25, 31'd99, 31'd100,
        31'd65535, 31'd65536, 31'h4000_0000, 31'd2147395599,
        31'd2147395600, 31'd2147395601, 31'h7FFF_FFFF,
        31'h5555_5555, 31'h2AAA_AAAA
    };

    integer_square_root_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && request.valid && request.ready)
        begin
            roots.note_value(request.value);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && response.valid && response.ready)
        begin
            roots.check_root(response.root);
        end
    end

    function automatic logic [isr_pkg::VALUE_W-1:0] random_value();
        logic [31:0] k;
        logic [31:0] word;
        k = $urandom_range(0, 46340);
        case ($urandom_range(0, 5))
            0: word = $urandom;
            1: word = $urandom_range(0, 255);
            2: word = k * k;
            3: word = k * k - 1;
            4: word = k * k + 1;
            default: word = $urandom & $urandom;
        endcase
        return word[isr_pkg::VALUE_W-1:0];
    endfunction

    task automatic send_value(input logic [isr_pkg::VALUE_W-1:0] value);
        int unsigned gap;
        if (req_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            request.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request.valid <= 1'b1;
        request.value <= value;
        do
            @(posedge clk);
        while (!request.ready);
    endtask

    task automatic wait_for_roots();
        while (roots.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int unsigned burst;
        response.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                response.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_pending = 1'b0;
                response.ready <= 1'b1;
            end
            else if (rsp_stalls_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 16);
                response.ready <= 1'b0;
                repeat (burst) @(negedge clk);
                response.ready <= 1'b1;
            end
            else
            begin
                response.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        request.valid    = 1'b0;
        request.value    = '0;
        req_gaps_on      = 1'b0;
        rsp_stalls_on    = 1'b0;
        hold_off_pending = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        foreach (directed_values[i])
        begin
            send_value(directed_values[i]);
        end
        @(negedge clk);
        request.valid <= 1'b0;
        wait_for_roots();

        // hold the response side while requests keep coming
        req_gaps_on      = 1'b0;
        hold_off_pending = 1'b1;
        for (int unsigned i = 0; i < BURST_ITEMS; i++)
        begin
            send_value(random_value());
        end
        @(negedge clk);
        request.valid <= 1'b0;
        wait_for_roots();

        req_gaps_on = 1'b1;
        for (int unsigned i = 0; i < RANDOM_ITEMS - QUIET_ITEMS; i++)
        begin
            send_value(random_value());
            if (i == (RANDOM_ITEMS - QUIET_ITEMS) / 2)
            begin
                @(negedge clk);
                request.valid <= 1'b0;
                wait_for_roots();
            end
        end

        // run back to back with no idling
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        for (int unsigned i = 0; i < QUIET_ITEMS; i++)
        begin
            send_value(random_value());
        end
        @(negedge clk);
        request.valid <= 1'b0;

        wait_for_roots();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (roots.failures == 0 && roots.outstanding() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### integer_square_root_unit.f
hdl/isr_pkg.sv
hdl/isr_if.sv
hdl/isr_dp.sv
hdl/isr_ctrl.sv
hdl/integer_square_root_unit.sv
tb/root_scoreboard_pkg.sv
tb/tb_integer_square_root_unit.sv
